@@ sv/kpcbd_pkg.sv @@
// Package: shared types and constants of the key press counter batch drain unit.
package kpcbd_pkg;

	localparam int KEY_POSITIONS_DEF      = 64;
	localparam int ENTRIES_PER_PACKET_DEF = 8;
	localparam logic [15:0] FLUSH_INTERVAL_RST = 16'd45;
	localparam logic [15:0] COUNT_MAX          = 16'hFFFF;

	typedef struct packed {
		logic       kind;
		logic [7:0] key_position;
		logic       pressed;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  entry_position;
		logic [15:0] press_count;
		logic [2:0]  slot_in_packet;
		logic        end_of_packet;
		logic        more_pending;
		logic        last;
	} out_item_t;

	localparam logic KIND_KEY  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic accept;
		logic rd_scan;
		logic clr_ptr;
		logic adv_ptr;
		logic inc_wr;
		logic pend_load;
		logic emit;
		logic emit_last;
	} cmd_t;

	typedef struct packed {
		logic press_ok;
		logic drain_go;
		logic hit;
		logic at_end;
		logic pend_valid;
		logic out_free;
	} status_t;

endpackage

@@ sv/kpcbd_ctrl.sv @@
// Controller: state machine sequencing key updates and the counter drain walk.
module kpcbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  kpcbd_pkg::status_t st,
	output kpcbd_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INC,
		S_SCAN,
		S_LOAD,
		S_FINAL
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.press_ok) begin
						state_nx = S_INC;
					end else if (st.drain_go) begin
						cmd.clr_ptr = 1'b1;
						state_nx    = S_SCAN;
					end
				end
			end
			S_INC: begin
				cmd.inc_wr = 1'b1;
				state_nx   = S_IDLE;
			end
			S_SCAN: begin
				if (st.hit) begin
					cmd.rd_scan = 1'b1;
					state_nx    = S_LOAD;
				end else if (st.at_end) begin
					state_nx = S_FINAL;
				end else begin
					cmd.adv_ptr = 1'b1;
				end
			end
			S_LOAD: begin
				if (!st.pend_valid || st.out_free) begin
					cmd.pend_load = 1'b1;
					cmd.emit      = st.pend_valid;
					if (st.at_end) begin
						state_nx = S_FINAL;
					end else begin
						cmd.adv_ptr = 1'b1;
						state_nx    = S_SCAN;
					end
				end
			end
			S_FINAL: begin
				if (!st.pend_valid) begin
					state_nx = S_IDLE;
				end else if (st.out_free) begin
					cmd.emit_last = 1'b1;
					state_nx      = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_last) |-> st.out_free)
		else $error("entry pushed into a busy output register");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !st.pend_valid)
		else $error("pending entry left over after drain");

	a_last_pend: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_last |-> st.pend_valid)
		else $error("final entry emitted with nothing pending");

	a_scan_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_scan |=> (state_q == S_LOAD))
		else $error("scan read not followed by load");

endmodule

@@ sv/kpcbd_dp.sv @@
// Datapath: counter memory, valid bits, inactivity timer, drain pointer, pending entry and output registers.
module kpcbd_dp #(
	parameter int KEY_POSITIONS      = kpcbd_pkg::KEY_POSITIONS_DEF,
	parameter int ENTRIES_PER_PACKET = kpcbd_pkg::ENTRIES_PER_PACKET_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  kpcbd_pkg::in_item_t  in_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output kpcbd_pkg::out_item_t out_data,
	input  kpcbd_pkg::cmd_t      cmd,
	output kpcbd_pkg::status_t   st
);

	localparam int PTR_W = (KEY_POSITIONS > 1) ? $clog2(KEY_POSITIONS) : 1;
	localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(KEY_POSITIONS - 1);
	localparam logic [2:0]       SLOT_END = 3'(ENTRIES_PER_PACKET - 1);

	logic [15:0]              mem [KEY_POSITIONS];
	logic [KEY_POSITIONS-1:0] vld_q;
	logic [15:0]              rdata_q;
	logic                     rvld_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [PTR_W-1:0]         key_q;
	logic [PTR_W-1:0]         rd_addr;
	logic                     rd_en;
	logic [15:0]              interval_q;
	logic [15:0]              idle_q;
	logic                     armed_q;
	logic [15:0]              idle_nx;
	logic [15:0]              cur_cnt;
	logic [15:0]              inc_cnt;
	logic [PTR_W-1:0]         pend_pos_q;
	logic [15:0]              pend_cnt_q;
	logic                     pend_valid_q;
	logic [2:0]               slot_q;
	logic                     full_end;
	logic                     out_valid_q;
	kpcbd_pkg::out_item_t     out_q;

	assign rd_en   = cmd.accept || cmd.rd_scan;
	assign rd_addr = cmd.accept ? in_data.key_position[PTR_W-1:0] : ptr_q;
	assign idle_nx = (idle_q == kpcbd_pkg::COUNT_MAX) ? idle_q : idle_q + 16'd1;
	assign cur_cnt = rvld_q ? rdata_q : 16'd0;
	assign inc_cnt = (cur_cnt == kpcbd_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 16'd1;
	assign full_end = (slot_q == SLOT_END);

	assign st.press_ok   = (in_data.kind == kpcbd_pkg::KIND_KEY) && in_data.pressed
		&& ({1'b0, in_data.key_position} < 9'(KEY_POSITIONS));
	assign st.drain_go   = (in_data.kind == kpcbd_pkg::KIND_TICK) && armed_q
		&& (idle_nx >= interval_q);
	assign st.hit        = vld_q[ptr_q];
	assign st.at_end     = (ptr_q == PTR_END);
	assign st.pend_valid = pend_valid_q;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (cmd.inc_wr) begin
			mem[key_q] <= inc_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= in_data.key_position[PTR_W-1:0];
		end
		if (rd_en) begin
			rvld_q <= vld_q[rd_addr];
		end
		if (cmd.pend_load) begin
			pend_pos_q <= ptr_q;
			pend_cnt_q <= rdata_q;
		end
		if (cmd.emit) begin
			out_q.entry_position <= 8'(pend_pos_q);
			out_q.press_count    <= pend_cnt_q;
			out_q.slot_in_packet <= slot_q;
			out_q.end_of_packet  <= full_end;
			out_q.more_pending   <= full_end;
			out_q.last           <= 1'b0;
		end else if (cmd.emit_last) begin
			out_q.entry_position <= 8'(pend_pos_q);
			out_q.press_count    <= pend_cnt_q;
			out_q.slot_in_packet <= slot_q;
			out_q.end_of_packet  <= 1'b1;
			out_q.more_pending   <= 1'b0;
			out_q.last           <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q        <= '0;
			interval_q   <= kpcbd_pkg::FLUSH_INTERVAL_RST;
			idle_q       <= '0;
			armed_q      <= 1'b0;
			ptr_q        <= '0;
			pend_valid_q <= 1'b0;
			slot_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (st.press_ok) begin
					armed_q <= 1'b1;
					idle_q  <= '0;
				end else if (st.drain_go) begin
					idle_q <= '0;
				end else if (in_data.kind == kpcbd_pkg::KIND_TICK && armed_q) begin
					idle_q <= idle_nx;
				end
			end
			if (cmd.inc_wr) begin
				vld_q[key_q] <= 1'b1;
			end
			if (cmd.rd_scan) begin
				vld_q[ptr_q] <= 1'b0;
			end
			if (cmd.clr_ptr) begin
				ptr_q  <= '0;
				slot_q <= '0;
			end else if (cmd.adv_ptr) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.emit) begin
				slot_q <= full_end ? 3'd0 : slot_q + 3'd1;
			end
			if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.emit_last) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.emit || cmd.emit_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_armed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |=> armed_q)
		else $error("timer disarmed after arming");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_END)
		else $error("packet slot beyond packet size");

	a_scan_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_scan |=> rvld_q && (rdata_q != 16'd0))
		else $error("drained entry read back as zero");

endmodule

@@ sv/key_press_counter_batch_drain_unit.sv @@
// Top level: key press counter with periodic batch drain.
// Input channel (in_valid/in_ready/in_data) takes key events and timer ticks.
// A key-down event for a position below KEY_POSITIONS bumps its saturating
// 16-bit counter and restarts the inactivity timer; it is handled as a
// counter memory read on acceptance, then a write in S_INC. Releases,
// out-of-range keys and ticks that start no drain leave the controller idle.
// A tick that brings the armed timer to or past flush_interval starts a drain:
// the controller walks all KEY_POSITIONS entries, one per cycle, with an extra
// load step (S_LOAD) per nonzero entry and a wait while the receiver stalls;
// input is held off meanwhile.
// One entry is held back in a lookahead register so its last/more_pending
// flags are known before it is sent on the output channel
// (out_valid/out_ready/out_data), which has a one-entry output register.
// A receiver stall freezes the walk at a nonzero entry while one is pending;
// the input channel reopens once the final entry sits in the output register.
// Reset clears all counters (valid bits), disarms the timer and loads the
// flush interval with 45; cfg_we writes a new interval from cfg_data.
module key_press_counter_batch_drain_unit #(
	parameter int KEY_POSITIONS      = kpcbd_pkg::KEY_POSITIONS_DEF,
	parameter int ENTRIES_PER_PACKET = kpcbd_pkg::ENTRIES_PER_PACKET_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  kpcbd_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output kpcbd_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data
);

	kpcbd_pkg::cmd_t    cmd;
	kpcbd_pkg::status_t st;

	kpcbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	kpcbd_dp #(
		.KEY_POSITIONS      (KEY_POSITIONS),
		.ENTRIES_PER_PACKET (ENTRIES_PER_PACKET)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the key press counter batch drain unit: directed and random key/tick traffic checked against a cycle-free count model.
module tb_top;

	localparam int KEYS          = kpcbd_pkg::KEY_POSITIONS_DEF;
	localparam int KW            = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int PKT           = kpcbd_pkg::ENTRIES_PER_PACKET_DEF;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 30;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	kpcbd_pkg::in_item_t  in_data  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	kpcbd_pkg::out_item_t out_data;
	logic                 cfg_we   = 1'b0;
	logic [15:0]          cfg_data = '0;

	logic [15:0]          press_tally[KEYS];
	logic                 timer_on;
	logic [15:0]          ticks_idle;
	logic [15:0]          interval_now;
	kpcbd_pkg::out_item_t drained_q[$];

	int errors       = 0;
	bit calm         = 1'b0;
	int hold_reqs    = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int stall_cycles = 0;

	key_press_counter_batch_drain_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic kpcbd_pkg::in_item_t make_event(logic k, logic [7:0] pos, logic dn);
		make_event = '{kind: k, key_position: pos, pressed: dn};
	endfunction

	function automatic void drain_counts();
		int                   hits[$];
		kpcbd_pkg::out_item_t e;
		for (int p = 0; p < KEYS; p++) begin
			if (press_tally[p] != 16'd0)
				hits.push_back(p);
		end
		foreach (hits[k]) begin
			e.entry_position = 8'(hits[k]);
			e.press_count    = press_tally[hits[k]];
			e.slot_in_packet = 3'(k % PKT);
			e.last           = (k == hits.size() - 1);
			e.more_pending   = (k % PKT == PKT - 1) && !e.last;
			e.end_of_packet  = (k % PKT == PKT - 1) || e.last;
			drained_q.push_back(e);
			press_tally[hits[k]] = 16'd0;
		end
	endfunction

	function automatic void count_event(kpcbd_pkg::in_item_t it);
		logic [KW-1:0] idx;
		idx = it.key_position[KW-1:0];
		if (it.kind == kpcbd_pkg::KIND_KEY) begin
			if (it.pressed && it.key_position < KEYS) begin
				if (press_tally[idx] != kpcbd_pkg::COUNT_MAX)
					press_tally[idx]++;
				timer_on   = 1'b1;
				ticks_idle = '0;
			end
		end else if (timer_on) begin
			if (ticks_idle != kpcbd_pkg::COUNT_MAX)
				ticks_idle++;
			if (ticks_idle >= interval_now) begin
				ticks_idle = '0;
				drain_counts();
			end
		end
	endfunction

	task automatic send_item(kpcbd_pkg::in_item_t it);
		if (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		count_event(it);
	endtask

	task automatic send_press(logic [7:0] pos);
		send_item(make_event(kpcbd_pkg::KIND_KEY, pos, 1'b1));
	endtask

	task automatic send_tick();
		send_item(make_event(kpcbd_pkg::KIND_TICK, 8'($urandom), 1'($urandom)));
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		while (drained_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_interval(logic [15:0] v);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we       <= 1'b0;
		interval_now = v;
	endtask

	task automatic test_reset_interval();
		send_item(make_event(kpcbd_pkg::KIND_TICK, 8'hFF, 1'b1));
		send_item(make_event(kpcbd_pkg::KIND_TICK, 8'h00, 1'b0));
		send_item(make_event(kpcbd_pkg::KIND_KEY, 8'd3, 1'b0));
		send_item(make_event(kpcbd_pkg::KIND_KEY, 8'd64, 1'b1));
		send_item(make_event(kpcbd_pkg::KIND_KEY, 8'd255, 1'b1));
		send_press(8'd0);
		send_press(8'd63);
		send_press(8'd63);
		send_item(make_event(kpcbd_pkg::KIND_KEY, 8'd63, 1'b0));
		repeat (kpcbd_pkg::FLUSH_INTERVAL_RST) send_tick();
		send_tick();
	endtask

	task automatic test_packets();
		set_interval(16'd1);
		for (int p = 0; p <= PKT; p++)
			send_press(8'(p));
		send_tick();
		send_tick();
		for (int p = KEYS - 1; p >= 0; p--)
			send_press(8'(p));
		send_press(8'd7);
		send_tick();
	endtask

	task automatic test_long_interval();
		set_interval(16'hFFFF);
		calm = 1'b1;
		repeat (4) send_press(8'd5);
		send_press(8'd6);
		repeat (10) send_tick();
		calm = 1'b0;
	endtask

	task automatic test_interval_shrink();
		send_press(8'd10);
		repeat (5) send_tick();
		set_interval(16'd3);
		send_tick();
		repeat (3) send_tick();
		send_press(8'd20);
		send_press(8'd20);
		repeat (3) send_tick();
	endtask

	task automatic test_backpressure();
		set_interval(16'd1);
		for (int p = 0; p < 24; p++)
			send_press(8'(2 * p + 1));
		hold_reqs++;
		send_tick();
		repeat (10) send_press(8'($urandom_range(KEYS - 1)));
		send_tick();
		// hold the sender until the drain has gone out
		wait_results();
		repeat (4) send_press(8'($urandom_range(KEYS - 1)));
		send_tick();
	endtask

	task automatic test_random();
		int          r;
		logic [15:0] iv;
		logic [7:0]  pos;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: iv = 16'd1;
				1: iv = 16'd2;
				default: iv = 16'($urandom_range(1, 10));
			endcase
			set_interval(iv);
			calm = (ph == 2);
			repeat (PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 55) begin
					pos = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom_range(KEYS - 1));
					send_press(pos);
				end else if (r < 65) begin
					send_item(make_event(kpcbd_pkg::KIND_KEY, 8'($urandom), 1'b0));
				end else if (r < 72) begin
					send_press(8'($urandom_range(KEYS, 255)));
				end else begin
					send_tick();
				end
			end
			calm = 1'b0;
		end
	endtask

	always @(posedge clk) begin : take_results
		kpcbd_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (drained_q.size() == 0) begin
				errors++;
				$display("%0t: expected no entry, actual pos %0d count %0d", $time,
					out_data.entry_position, out_data.press_count);
			end else begin
				want = drained_q.pop_front();
				if (out_data !== want) begin
					errors++;
					$display("%0t: expected pos %0d count %0d slot %0d eop %0b more %0b last %0b",
						$time, want.entry_position, want.press_count, want.slot_in_packet,
						want.end_of_packet, want.more_pending, want.last);
					$display("%0t: actual   pos %0d count %0d slot %0d eop %0b more %0b last %0b",
						$time, out_data.entry_position, out_data.press_count,
						out_data.slot_in_packet, out_data.end_of_packet,
						out_data.more_pending, out_data.last);
				end
			end
		end
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && (calm || $urandom_range(99) >= 12);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		foreach (press_tally[p])
			press_tally[p] = '0;
		timer_on     = 1'b0;
		ticks_idle   = '0;
		interval_now = kpcbd_pkg::FLUSH_INTERVAL_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_interval();
		test_packets();
		test_long_interval();
		test_interval_shrink();
		test_backpressure();
		test_random();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && drained_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/kpcbd_pkg.sv
sv/kpcbd_ctrl.sv
sv/kpcbd_dp.sv
sv/key_press_counter_batch_drain_unit.sv
bench/tb_top.sv
